// ----- hw/rtl/min_heap_timer_queue_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the min-heap timer queue
// Shared property wrappers, clocked on clk_i and disabled during reset.
// ----------------------------------------------------------------------------
`ifndef MIN_HEAP_TIMER_QUEUE_ASSERT_SVH
`define MIN_HEAP_TIMER_QUEUE_ASSERT_SVH

// Invariant that holds at every clock edge
`define MHTQ_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition that implies a consequence in the next cycle
`define MHTQ_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) else $error(msg);

`endif

// ----- hw/rtl/mhtq_pkg.sv -----
// ----------------------------------------------------------------------------
// mhtq_pkg
// Codes, entry and result types shared by the min-heap timer queue.
// ----------------------------------------------------------------------------
package mhtq_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int ID_COUNT_DEF = 1024;

  localparam int ID_W   = 10;
  localparam int TIME_W = 32;
  localparam int TMO_W  = 31;

  // Commands
  localparam logic [2:0] CMD_ADD   = 3'd0;
  localparam logic [2:0] CMD_ADJ   = 3'd1;
  localparam logic [2:0] CMD_FIRE  = 3'd2;
  localparam logic [2:0] CMD_TICK  = 3'd3;
  localparam logic [2:0] CMD_NEXT  = 3'd4;
  localparam logic [2:0] CMD_CLEAR = 3'd5;

  // Result kinds
  localparam logic [1:0] KIND_FIRED = 2'd0;
  localparam logic [1:0] KIND_WAIT  = 2'd1;
  localparam logic [1:0] KIND_ACK   = 2'd2;
  localparam logic [1:0] KIND_ERR   = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE   = 2'd0;
  localparam logic [1:0] ERR_FULL   = 2'd1;
  localparam logic [1:0] ERR_ABSENT = 2'd2;

  localparam logic [TIME_W-1:0] WAIT_EMPTY = '1;
  localparam logic [TIME_W-1:0] WAIT_MAX   = 32'h7FFF_FFFF;

  // One heap slot
  typedef struct packed {
    logic [TIME_W-1:0] expiry;
    logic [ID_W-1:0]   owner;
  } entry_t;

  // One result word
  typedef struct packed {
    logic [1:0]        kind;
    logic [ID_W-1:0]   fired_id;
    logic [TIME_W-1:0] wait_ms;
    logic [1:0]        error_code;
    logic              last;
  } result_t;

endpackage

// ----- hw/rtl/mhtq_heap_ram.sv -----
// ----------------------------------------------------------------------------
// mhtq_heap_ram
// Heap slot memory: two registered read ports, one write port.
// ----------------------------------------------------------------------------
module mhtq_heap_ram #(
  parameter int DEPTH = mhtq_pkg::CAPACITY_DEF,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic [AW-1:0]       ra_addr_i,
  input  logic [AW-1:0]       rb_addr_i,
  output mhtq_pkg::entry_t    ra_data_o,
  output mhtq_pkg::entry_t    rb_data_o,
  input  logic                we_i,
  input  logic [AW-1:0]       waddr_i,
  input  mhtq_pkg::entry_t    wdata_i
);

  mhtq_pkg::entry_t mem [DEPTH];

  // Write one slot
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read two slots into registered outputs
  always_ff @(posedge clk_i) begin
    ra_data_o <= mem[ra_addr_i];
    rb_data_o <= mem[rb_addr_i];
  end

endmodule

// ----- hw/rtl/mhtq_id_map.sv -----
// ----------------------------------------------------------------------------
// mhtq_id_map
// Id-to-slot memory: one registered read port, one write port.
// ----------------------------------------------------------------------------
module mhtq_id_map #(
  parameter int DEPTH = mhtq_pkg::ID_COUNT_DEF,
  parameter int AW    = $clog2(DEPTH),
  parameter int DW    = $clog2(mhtq_pkg::CAPACITY_DEF)
) (
  input  logic          clk_i,
  input  logic          rd_en_i,
  input  logic [AW-1:0] rd_addr_i,
  output logic [DW-1:0] rd_data_o,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i
);

  logic [DW-1:0] mem [DEPTH];

  // Write one id
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read on request, hold otherwise
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_o <= mem[rd_addr_i];
    end
  end

endmodule

// ----- hw/rtl/mhtq_out_reg.sv -----
// ----------------------------------------------------------------------------
// mhtq_out_reg
// Output register for result words with valid/ready.
// ----------------------------------------------------------------------------
module mhtq_out_reg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              load_i,
  input  mhtq_pkg::result_t res_i,
  output logic              can_load_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output mhtq_pkg::result_t res_o
);

  logic valid_q, valid_d;
  mhtq_pkg::result_t res_q;

  assign can_load_o  = !valid_q || out_ready_i;
  assign out_valid_o = valid_q;
  assign res_o       = res_q;

  // Hold until taken, refill on load
  always_comb begin
    valid_d = valid_q;
    if (load_i) begin
      valid_d = 1'b1;
    end else if (out_ready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      res_q <= res_i;
    end
  end

endmodule

// ----- hw/rtl/min_heap_timer_queue.sv -----
// ----------------------------------------------------------------------------
// min_heap_timer_queue
// Binary min-heap of timers ordered by expiry, with an id-to-slot map. Heap
// slots and the id map sit in synchronous memories with registered reads. A
// sequencer walks the heap path, visiting each level by issuing the read,
// then comparing and writing back, and finally writes the moving node into
// its final slot. An add or adjust reads the id map, checks the slot, then
// sifts; a fire reads the map, checks the slot, then deletes it; a tick or
// next-wait checks the root, then fires and deletes each expired root.
// A delete fetches the tail entry into the hole, then sifts it. The result
// side can stall the sequencer. One item is worked on at a time; in_ready_o
// is high only while the sequencer idles. An id is taken as present when its
// mapped slot lies below the entry count and that slot's owner matches, so
// clear only zeroes the count and no clearing pass exists. A read may hit
// the slot being written in one cycle and then returns the old entry.
// ----------------------------------------------------------------------------
module min_heap_timer_queue #(
  parameter int CAPACITY = mhtq_pkg::CAPACITY_DEF,
  parameter int ID_COUNT = mhtq_pkg::ID_COUNT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [2:0]                         command_i,
  input  logic [mhtq_pkg::ID_W-1:0]          timer_id_i,
  input  logic [mhtq_pkg::TMO_W-1:0]         timeout_ms_i,
  input  logic [mhtq_pkg::TIME_W-1:0]        now_ms_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic [1:0]                         kind_o,
  output logic [mhtq_pkg::ID_W-1:0]          fired_id_o,
  output logic signed [mhtq_pkg::TIME_W-1:0] wait_ms_o,
  output logic [1:0]                         error_code_o,
  output logic                               last_o
);

`include "min_heap_timer_queue_assert.svh"

  localparam int SlotW = $clog2(CAPACITY);
  localparam int CntW  = $clog2(CAPACITY + 1);
  localparam int ChW   = SlotW + 2;
  localparam int IdxW  = $clog2(ID_COUNT);
  localparam int TW    = mhtq_pkg::TIME_W;

  localparam logic [3:0] ST_IDLE       = 4'd0;
  localparam logic [3:0] ST_DISPATCH   = 4'd1;
  localparam logic [3:0] ST_MAP_RD     = 4'd2;
  localparam logic [3:0] ST_CHECK      = 4'd3;
  localparam logic [3:0] ST_DEL_RD     = 4'd4;
  localparam logic [3:0] ST_SD_ISSUE   = 4'd5;
  localparam logic [3:0] ST_SD_CMP     = 4'd6;
  localparam logic [3:0] ST_SU_ISSUE   = 4'd7;
  localparam logic [3:0] ST_SU_CMP     = 4'd8;
  localparam logic [3:0] ST_TICK_ISSUE = 4'd9;
  localparam logic [3:0] ST_TICK_CHK   = 4'd10;
  localparam logic [3:0] ST_DONE       = 4'd11;

  logic [3:0] state_q, state_d;
  logic [2:0] cmd_q, cmd_d;
  logic [mhtq_pkg::ID_W-1:0] id_q, id_d;
  logic [TW-1:0] exp_q, exp_d, now_q, now_d;
  logic [CntW-1:0] count_q, count_d;
  logic [SlotW-1:0] i_q, i_d, start_q, start_d;
  logic up_q, up_d, has2_q, has2_d;
  mhtq_pkg::entry_t node_q, node_d;
  mhtq_pkg::result_t res_q, res_d;

  // Memory ports
  logic [SlotW-1:0] ra_addr, rb_addr, hw_addr;
  mhtq_pkg::entry_t ra_data, rb_data, hw_data, child;
  logic hw_en;
  logic mr_en, mw_en;
  logic [IdxW-1:0] mr_addr, mw_addr;
  logic [SlotW-1:0] mr_data, mw_data;

  // Output side
  logic emit, can_emit;
  mhtq_pkg::result_t emit_res, out_res;

  logic [TW:0] exp_sum;
  logic [ChW-1:0] c1, c2;
  logic [SlotW-1:0] parent, del_idx;
  logic [CntW-1:0] del_n;
  logic [TW-1:0] wait_diff;
  logic id_ok, present, tick_mode, pick_b, sd_done, su_done;
  logic [3:0] fin_state;

  assign exp_sum   = {1'b0, now_ms_i} + {2'b00, timeout_ms_i};
  assign id_ok     = {22'd0, id_q} < ID_COUNT;
  assign present   = (CntW'(mr_data) < count_q) && (ra_data.owner == id_q);
  assign tick_mode = (cmd_q == mhtq_pkg::CMD_TICK) || (cmd_q == mhtq_pkg::CMD_NEXT);
  assign fin_state = tick_mode ? ST_TICK_ISSUE :
                     ((cmd_q == mhtq_pkg::CMD_FIRE) ? ST_IDLE : ST_DONE);
  assign c1        = {1'b0, i_q, 1'b1};
  assign c2        = c1 + ChW'(1);
  assign parent    = SlotW'((i_q - SlotW'(1)) >> 1);
  assign pick_b    = has2_q && (rb_data.expiry < ra_data.expiry);
  assign child     = pick_b ? rb_data : ra_data;
  assign del_idx   = (state_q == ST_CHECK) ? mr_data : '0;
  assign del_n     = count_q - CntW'(1);
  assign wait_diff = ra_data.expiry - now_q;
  assign in_ready_o = (state_q == ST_IDLE);

  // Sequencer
  always_comb begin
    state_d = state_q;
    cmd_d   = cmd_q;
    id_d    = id_q;
    exp_d   = exp_q;
    now_d   = now_q;
    count_d = count_q;
    i_d     = i_q;
    start_d = start_q;
    up_d    = up_q;
    has2_d  = has2_q;
    node_d  = node_q;
    res_d   = res_q;
    ra_addr = '0;
    rb_addr = '0;
    hw_en   = 1'b0;
    hw_addr = i_q;
    hw_data = node_q;
    mr_en   = 1'b0;
    mr_addr = IdxW'(id_q);
    mw_en   = 1'b0;
    mw_addr = IdxW'(node_q.owner);
    mw_data = i_q;
    emit    = 1'b0;
    emit_res = '0;
    sd_done = 1'b0;
    su_done = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_d   = command_i;
          id_d    = timer_id_i;
          exp_d   = exp_sum[TW] ? '1 : exp_sum[TW-1:0];
          now_d   = now_ms_i;
          state_d = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        res_d      = '0;
        res_d.kind = mhtq_pkg::KIND_ACK;
        res_d.last = 1'b1;
        unique case (cmd_q)
          mhtq_pkg::CMD_ADD, mhtq_pkg::CMD_ADJ, mhtq_pkg::CMD_FIRE: begin
            if (!id_ok) begin
              res_d.kind       = mhtq_pkg::KIND_ERR;
              res_d.error_code = mhtq_pkg::ERR_ABSENT;
              state_d          = ST_DONE;
            end else begin
              mr_en   = 1'b1;
              state_d = ST_MAP_RD;
            end
          end
          mhtq_pkg::CMD_TICK, mhtq_pkg::CMD_NEXT: begin
            state_d = ST_TICK_ISSUE;
          end
          mhtq_pkg::CMD_CLEAR: begin
            count_d = '0;
            state_d = ST_DONE;
          end
          default: begin
            state_d = ST_DONE;
          end
        endcase
      end
      ST_MAP_RD: begin
        ra_addr = mr_data;
        state_d = ST_CHECK;
      end
      ST_CHECK: begin
        // Keep the mapped slot on the read port while the result side stalls
        ra_addr = mr_data;
        unique case (cmd_q)
          mhtq_pkg::CMD_ADD: begin
            node_d = '{expiry: exp_q, owner: id_q};
            if (present) begin
              i_d     = mr_data;
              start_d = mr_data;
              up_d    = 1'b1;
              state_d = ST_SD_ISSUE;
            end else if (count_q >= CntW'(CAPACITY)) begin
              res_d.kind       = mhtq_pkg::KIND_ERR;
              res_d.error_code = mhtq_pkg::ERR_FULL;
              state_d          = ST_DONE;
            end else begin
              i_d     = SlotW'(count_q);
              count_d = count_q + CntW'(1);
              state_d = ST_SU_ISSUE;
            end
          end
          mhtq_pkg::CMD_ADJ: begin
            node_d = '{expiry: exp_q, owner: id_q};
            if (present) begin
              i_d     = mr_data;
              start_d = mr_data;
              up_d    = 1'b0;
              state_d = ST_SD_ISSUE;
            end else begin
              res_d.kind       = mhtq_pkg::KIND_ERR;
              res_d.error_code = mhtq_pkg::ERR_ABSENT;
              state_d          = ST_DONE;
            end
          end
          default: begin
            if (present) begin
              if (can_emit) begin
                emit              = 1'b1;
                emit_res.kind     = mhtq_pkg::KIND_FIRED;
                emit_res.fired_id = id_q;
                emit_res.last     = 1'b1;
                // Delete the slot: move the tail into the hole
                count_d = del_n;
                i_d     = del_idx;
                start_d = del_idx;
                if (CntW'(del_idx) < del_n) begin
                  ra_addr = SlotW'(del_n);
                  state_d = ST_DEL_RD;
                end else begin
                  state_d = fin_state;
                end
              end
            end else begin
              res_d.kind       = mhtq_pkg::KIND_ERR;
              res_d.error_code = mhtq_pkg::ERR_ABSENT;
              state_d          = ST_DONE;
            end
          end
        endcase
      end
      ST_DEL_RD: begin
        node_d  = ra_data;
        up_d    = 1'b1;
        state_d = ST_SD_ISSUE;
      end
      ST_SD_ISSUE: begin
        if (c1 < ChW'(count_q)) begin
          ra_addr = SlotW'(c1);
          rb_addr = SlotW'(c2);
          has2_d  = c2 < ChW'(count_q);
          state_d = ST_SD_CMP;
        end else begin
          sd_done = 1'b1;
        end
      end
      ST_SD_CMP: begin
        if (node_q.expiry < child.expiry) begin
          sd_done = 1'b1;
        end else begin
          // Pull the smaller child up into the hole
          hw_en   = 1'b1;
          hw_data = child;
          mw_en   = 1'b1;
          mw_addr = IdxW'(child.owner);
          i_d     = pick_b ? SlotW'(c2) : SlotW'(c1);
          state_d = ST_SD_ISSUE;
        end
      end
      ST_SU_ISSUE: begin
        if (i_q == '0) begin
          su_done = 1'b1;
        end else begin
          ra_addr = parent;
          state_d = ST_SU_CMP;
        end
      end
      ST_SU_CMP: begin
        if (ra_data.expiry < node_q.expiry) begin
          su_done = 1'b1;
        end else begin
          // Push the parent down into the hole
          hw_en   = 1'b1;
          hw_data = ra_data;
          mw_en   = 1'b1;
          mw_addr = IdxW'(ra_data.owner);
          i_d     = parent;
          state_d = ST_SU_ISSUE;
        end
      end
      ST_TICK_ISSUE: begin
        if (count_q == '0) begin
          if (cmd_q == mhtq_pkg::CMD_NEXT) begin
            res_d.kind    = mhtq_pkg::KIND_WAIT;
            res_d.wait_ms = mhtq_pkg::WAIT_EMPTY;
          end
          state_d = ST_DONE;
        end else begin
          ra_addr = '0;
          state_d = ST_TICK_CHK;
        end
      end
      ST_TICK_CHK: begin
        if (ra_data.expiry <= now_q) begin
          if (can_emit) begin
            emit              = 1'b1;
            emit_res.kind     = mhtq_pkg::KIND_FIRED;
            emit_res.fired_id = ra_data.owner;
            count_d = del_n;
            i_d     = del_idx;
            start_d = del_idx;
            if (CntW'(del_idx) < del_n) begin
              ra_addr = SlotW'(del_n);
              state_d = ST_DEL_RD;
            end else begin
              state_d = fin_state;
            end
          end
        end else begin
          if (cmd_q == mhtq_pkg::CMD_NEXT) begin
            res_d.kind    = mhtq_pkg::KIND_WAIT;
            res_d.wait_ms = wait_diff[TW-1] ? mhtq_pkg::WAIT_MAX : wait_diff;
          end
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (can_emit) begin
          emit     = 1'b1;
          emit_res = res_q;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    // Sift-down end: settle the node, or turn around and sift up
    if (sd_done) begin
      if ((i_q != start_q) || !up_q) begin
        hw_en   = 1'b1;
        mw_en   = 1'b1;
        state_d = fin_state;
      end else begin
        state_d = ST_SU_ISSUE;
      end
    end

    // Sift-up end: settle the node
    if (su_done) begin
      hw_en   = 1'b1;
      mw_en   = 1'b1;
      state_d = fin_state;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q   <= cmd_d;
    id_q    <= id_d;
    exp_q   <= exp_d;
    now_q   <= now_d;
    i_q     <= i_d;
    start_q <= start_d;
    up_q    <= up_d;
    has2_q  <= has2_d;
    node_q  <= node_d;
    res_q   <= res_d;
  end

  mhtq_heap_ram #(
    .DEPTH (CAPACITY),
    .AW    (SlotW)
  ) u_heap (
    .clk_i     (clk_i),
    .ra_addr_i (ra_addr),
    .rb_addr_i (rb_addr),
    .ra_data_o (ra_data),
    .rb_data_o (rb_data),
    .we_i      (hw_en),
    .waddr_i   (hw_addr),
    .wdata_i   (hw_data)
  );

  mhtq_id_map #(
    .DEPTH (ID_COUNT),
    .AW    (IdxW),
    .DW    (SlotW)
  ) u_map (
    .clk_i     (clk_i),
    .rd_en_i   (mr_en),
    .rd_addr_i (mr_addr),
    .rd_data_o (mr_data),
    .we_i      (mw_en),
    .waddr_i   (mw_addr),
    .wdata_i   (mw_data)
  );

  mhtq_out_reg u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (emit),
    .res_i       (emit_res),
    .can_load_o  (can_emit),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .res_o       (out_res)
  );

  assign kind_o       = out_res.kind;
  assign fired_id_o   = out_res.fired_id;
  assign wait_ms_o    = $signed(out_res.wait_ms);
  assign error_code_o = out_res.error_code;
  assign last_o       = out_res.last;

  `MHTQ_ASSERT(a_count_in_range, count_q <= CntW'(CAPACITY), "entry count above capacity")
  `MHTQ_ASSERT(a_heap_wr_live, !hw_en || (CntW'(hw_addr) < count_q), "heap write past count")
  `MHTQ_ASSERT(a_emit_has_room, !emit || can_emit, "result word dropped")
  `MHTQ_ASSERT_NEXT(a_accept_dispatch, in_valid_i && in_ready_o, state_q == ST_DISPATCH, "accept lost")

endmodule
